FILE: rtl/shl_pkg.sv
// ----------------------------------------------------------------------------
// shl_pkg: shared types, constants and saturating arithmetic
// Widths, stage control struct and 64-bit saturating add, subtract and abs
// used by the shoelace area pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package shl_pkg;

	localparam int COORD_BITS   = 24;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS    = 2 * DIFF_BITS;
	localparam int SUM_BITS     = 64;
	localparam int IN_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic valid;
		logic ring_end;
		logic polygon_end;
		logic geometry_end;
		logic sat;          // some saturation already hit by this item
	} ctl_t;

	typedef struct packed {
		sum_t value;
		logic sat;
	} sat_res_t;

	function automatic sat_res_t sat_add(input sum_t a, input sum_t b);
		logic [SUM_BITS:0] s;
		sat_res_t r;
		s = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
		r.sat = s[SUM_BITS] ^ s[SUM_BITS-1];
		if (r.sat) begin
			r.value = s[SUM_BITS] ? SUM_MIN : SUM_MAX;
		end else begin
			r.value = s[SUM_BITS-1:0];
		end
		return r;
	endfunction

	function automatic sat_res_t sat_sub(input sum_t a, input sum_t b);
		logic [SUM_BITS:0] s;
		sat_res_t r;
		s = {a[SUM_BITS-1], a} - {b[SUM_BITS-1], b};
		r.sat = s[SUM_BITS] ^ s[SUM_BITS-1];
		if (r.sat) begin
			r.value = s[SUM_BITS] ? SUM_MIN : SUM_MAX;
		end else begin
			r.value = s[SUM_BITS-1:0];
		end
		return r;
	endfunction

	function automatic sat_res_t sat_abs(input sum_t a);
		sat_res_t r;
		r.sat = (a == SUM_MIN);
		if (r.sat) begin
			r.value = SUM_MAX;
		end else if (a[SUM_BITS-1]) begin
			r.value = -a;
		end else begin
			r.value = a;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/polygon_shoelace_area.sv
// ----------------------------------------------------------------------------
// polygon_shoelace_area: streaming doubled area of a multipolygon
// Takes one vertex per transaction and returns twice the total area, with a
// saturation flag, on the transaction that closes the geometry.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one vertex per transaction. tdata holds x then y (signed),
//   tuser[0] closes the ring, tuser[1] closes the polygon, tlast closes the
//   geometry. A polygon end also closes the ring; tlast closes both.
//   Master channel: one transaction per geometry. tdata is the doubled area
//   (signed, 64 bits, clamped), tuser[0] flags that some sum saturated.
//   Path: the tlast vertex loads the input register, then passes the term
//   multiply, ring sum, ring magnitude, polygon combine and total/result
//   register stages in that order.
//   Throughput: one vertex per cycle while s_tready is high. The ring,
//   polygon and total stages each close a loop of one 64-bit saturating add
//   or subtract, so nothing holds a vertex longer.
//   Stalls: vertices keep flowing while a result waits. The pipeline only
//   freezes (s_tready low) when a second result reaches the last stage
//   while the result register is still held by the receiver.
//   Reset: arst_n clears all sums and valid flags; the first vertex after
//   reset, and after every emitted result, starts a fresh geometry.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_shoelace_area (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire [shl_pkg::IN_DATA_BITS-1:0]  s_tdata,   // x_coord, y_coord
	input  wire [1:0]                        s_tuser,   // ring_end, polygon_end
	input  wire                              s_tlast,   // geometry_end
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [shl_pkg::SUM_BITS-1:0]     m_tdata,   // double_area
	output logic [0:0]                       m_tuser    // saturated
);

	logic            en;
	logic            stall;

	shl_pkg::ctl_t   ctl_s1;
	shl_pkg::coord_t x_s1;
	shl_pkg::coord_t y_s1;

	shl_pkg::ctl_t   ctl_s2;
	shl_pkg::sum_t   term_s2;
	shl_pkg::ctl_t   ctl_s4;
	shl_pkg::sum_t   mag_s4;
	shl_pkg::ctl_t   ctl_s5;
	shl_pkg::sum_t   poly_s5;

	logic            out_valid_q;
	shl_pkg::sum_t   area_q;
	logic            sat_q;

	// the whole pipeline advances together; bubbles flow through
	assign en       = !stall;
	assign s_tready = en;

	// input register; implied ends resolved here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid        <= s_tvalid;
			ctl_s1.geometry_end <= s_tlast;
			ctl_s1.polygon_end  <= s_tlast | s_tuser[1];
			ctl_s1.ring_end     <= s_tlast | s_tuser[1] | s_tuser[0];
			ctl_s1.sat          <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= s_tdata[shl_pkg::COORD_BITS-1:0];
			y_s1 <= s_tdata[2*shl_pkg::COORD_BITS-1:shl_pkg::COORD_BITS];
		end
	end

	shl_term u_term (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s1),
		.x_in    (x_s1),
		.y_in    (y_s1),
		.ctl_s2  (ctl_s2),
		.term_s2 (term_s2)
	);

	shl_ring_acc u_ring_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s2),
		.term_in (term_s2),
		.ctl_s4  (ctl_s4),
		.mag_s4  (mag_s4)
	);

	shl_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s4),
		.mag_in  (mag_s4),
		.ctl_s5  (ctl_s5),
		.poly_s5 (poly_s5)
	);

	shl_total u_total (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl_in      (ctl_s5),
		.poly_in     (poly_s5),
		.out_ready   (m_tready),
		.stall       (stall),
		.out_valid_q (out_valid_q),
		.area_q      (area_q),
		.sat_q       (sat_q)
	);

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = area_q;
	assign m_tuser[0] = sat_q;

endmodule

`default_nettype wire

FILE: rtl/shl_term.sv
// ----------------------------------------------------------------------------
// shl_term: ring vertex history and shoelace term
// Keeps the ring's first x, the last vertex and the y before it, and registers
// (x[k-1] - x0) * (y[k-2] - y[k]) for vertex k of 2 or more, else zero.
// ----------------------------------------------------------------------------
`default_nettype none

module shl_term (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  shl_pkg::ctl_t       ctl_in,
	input  shl_pkg::coord_t     x_in,
	input  shl_pkg::coord_t     y_in,
	output shl_pkg::ctl_t       ctl_s2,
	output shl_pkg::sum_t       term_s2
);

	localparam logic [1:0] CNT_ZERO = 2'd0;
	localparam logic [1:0] CNT_FULL = 2'd2;

	shl_pkg::coord_t first_x_q;
	shl_pkg::coord_t last_x_q;
	shl_pkg::coord_t last_y_q;
	shl_pkg::coord_t blast_y_q;
	logic [1:0]      count_q;

	shl_pkg::diff_t dx;
	shl_pkg::diff_t dy;
	shl_pkg::prod_t prod;
	logic           take;

	assign take = en && ctl_in.valid;

	always_comb begin
		dx   = shl_pkg::diff_t'(last_x_q) - shl_pkg::diff_t'(first_x_q);
		dy   = shl_pkg::diff_t'(blast_y_q) - shl_pkg::diff_t'(y_in);
		prod = shl_pkg::prod_t'(dx) * shl_pkg::prod_t'(dy);
	end

	// vertex history; only read once count reaches two within the ring
	always_ff @(posedge clk) begin
		if (take) begin
			if (count_q == CNT_ZERO) begin
				first_x_q <= x_in;
			end
			blast_y_q <= last_y_q;
			last_y_q  <= y_in;
			last_x_q  <= x_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_ZERO;
		end else if (take) begin
			if (ctl_in.ring_end) begin
				count_q <= CNT_ZERO;
			end else if (count_q != CNT_FULL) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (count_q == CNT_FULL) begin
				term_s2 <= {{(shl_pkg::SUM_BITS-shl_pkg::PROD_BITS){prod[shl_pkg::PROD_BITS-1]}},
					prod};
			end else begin
				term_s2 <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/shl_ring_acc.sv
// ----------------------------------------------------------------------------
// shl_ring_acc: ring sum accumulation and magnitude
// Stage 3 adds the term into the ring sum; stage 4 takes the saturated
// absolute value of a closed ring.
// ----------------------------------------------------------------------------
`default_nettype none

module shl_ring_acc (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  shl_pkg::ctl_t       ctl_in,
	input  shl_pkg::sum_t       term_in,
	output shl_pkg::ctl_t       ctl_s4,
	output shl_pkg::sum_t       mag_s4
);

	shl_pkg::sum_t    ring_sum_q;
	shl_pkg::ctl_t    ctl_s3;
	shl_pkg::sum_t    ring_s3;
	shl_pkg::sat_res_t acc;
	shl_pkg::sat_res_t mag;
	shl_pkg::ctl_t    ctl_acc;
	shl_pkg::ctl_t    ctl_mag;

	always_comb begin
		acc = shl_pkg::sat_add(ring_sum_q, term_in);
		mag = shl_pkg::sat_abs(ring_s3);
		ctl_acc     = ctl_in;
		ctl_acc.sat = ctl_in.sat | acc.sat;
		ctl_mag     = ctl_s3;
		ctl_mag.sat = ctl_s3.sat | (ctl_s3.ring_end & mag.sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_sum_q <= '0;
		end else if (en && ctl_in.valid) begin
			ring_sum_q <= ctl_in.ring_end ? '0 : acc.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_acc;
			ctl_s4 <= ctl_mag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_s3 <= acc.value;
			mag_s4  <= mag.value;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/shl_poly.sv
// ----------------------------------------------------------------------------
// shl_poly: polygon combine
// First ring sets the polygon value; each later ring is subtracted.
// ----------------------------------------------------------------------------
`default_nettype none

module shl_poly (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  shl_pkg::ctl_t       ctl_in,
	input  shl_pkg::sum_t       mag_in,
	output shl_pkg::ctl_t       ctl_s5,
	output shl_pkg::sum_t       poly_s5
);

	shl_pkg::sum_t     poly_q;
	logic              first_q;
	shl_pkg::sat_res_t diff;
	shl_pkg::sum_t     poly_val;
	logic              diff_sat;
	shl_pkg::ctl_t     ctl_out;

	always_comb begin
		diff        = shl_pkg::sat_sub(poly_q, mag_in);
		poly_val    = first_q ? mag_in : diff.value;
		diff_sat    = ctl_in.ring_end & ~first_q & diff.sat;
		ctl_out     = ctl_in;
		ctl_out.sat = ctl_in.sat | diff_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q  <= '0;
			first_q <= 1'b1;
		end else if (en && ctl_in.valid && ctl_in.ring_end) begin
			if (ctl_in.polygon_end) begin
				poly_q  <= '0;
				first_q <= 1'b1;
			end else begin
				poly_q  <= poly_val;
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s5 <= ctl_out;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			poly_s5 <= poly_val;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/shl_total.sv
// ----------------------------------------------------------------------------
// shl_total: geometry total and result register
// Adds closed polygons into the total, tracks saturation per geometry and
// holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module shl_total (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  shl_pkg::ctl_t       ctl_in,
	input  shl_pkg::sum_t       poly_in,
	input  wire                 out_ready,
	output logic                stall,
	output logic                out_valid_q,
	output shl_pkg::sum_t       area_q,
	output logic                sat_q
);

	shl_pkg::sum_t     total_q;
	logic              sticky_q;
	shl_pkg::sat_res_t tot;
	logic              item_sat;
	logic              take;

	always_comb begin
		tot      = shl_pkg::sat_add(total_q, poly_in);
		item_sat = ctl_in.sat | (ctl_in.polygon_end & tot.sat);
		take     = en && ctl_in.valid;
		// a result can only move on when the result register is free
		stall    = ctl_in.valid && ctl_in.geometry_end && out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			sticky_q <= 1'b0;
		end else if (take) begin
			if (ctl_in.geometry_end) begin
				total_q  <= '0;
				sticky_q <= 1'b0;
			end else begin
				if (ctl_in.polygon_end) begin
					total_q <= tot.value;
				end
				sticky_q <= sticky_q | item_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && ctl_in.geometry_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctl_in.geometry_end) begin
			area_q <= tot.value;
			sat_q  <= sticky_q | item_sat;
		end
	end

endmodule

`default_nettype wire
